// ----- hw/rtl/jls_pkg.sv -----
// Shared types and constants for the Jacobi linear solver.
// Used by jls_ctrl, jls_dp and jacobi_linear_solver; no dependencies.
package jls_pkg;

  localparam int DefNumUnknowns = 8;
  localparam int FracBits       = 16;
  // Wide enough for b_i minus fifteen truncated products.
  localparam int AccW           = 56;
  localparam int DivW           = AccW + FracBits;
  localparam int DivCntW        = $clog2(DivW);
  localparam int CfgIdxW        = 4;

  localparam logic [7:0]        IterReset  = 8'd10;
  localparam logic signed [31:0] GuessReset = 32'sd65536;

  localparam logic [CfgIdxW-1:0] CfgIterIdx  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgGuessIdx = 4'd1;

  typedef enum logic [1:0] {
    REQ_COEF  = 2'd0,
    REQ_RHS   = 2'd1,
    REQ_SOLVE = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef struct packed {
    logic ld_coef;
    logic ld_rhs;
    logic init;
    logic load_b;
    logic rd;
    logic mul;
    logic acc;
    logic diag;
    logic div_start;
    logic div_step;
    logic div_end;
    logic copy;
    logic out;
    logic out_last;
  } jls_cmd_t;

endpackage

// ----- hw/rtl/jls_ctrl.sv -----
// Sequencer of the Jacobi solver: request decode, sweep/row/column/divide counters.
// Depends on jls_pkg; drives jls_dp through a jls_cmd_t command struct.
module jls_ctrl #(
  parameter int NumUnknowns = jls_pkg::DefNumUnknowns,
  parameter int IdxW        = $clog2(NumUnknowns)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   req_type_i,
  input  logic [2:0]                   row_i,
  input  logic [2:0]                   col_i,
  input  logic                         cfg_we_i,
  input  logic [jls_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                   cfg_iter_i,
  output logic                         busy_o,
  output jls_pkg::jls_cmd_t            cmd_o,
  output logic [IdxW-1:0]              i_idx_o,
  output logic [IdxW-1:0]              j_idx_o
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_INIT = 11'b000_0000_0010,
    ST_ROW  = 11'b000_0000_0100,
    ST_RD   = 11'b000_0000_1000,
    ST_MUL  = 11'b000_0001_0000,
    ST_ACC  = 11'b000_0010_0000,
    ST_DIVS = 11'b000_0100_0000,
    ST_DIV  = 11'b000_1000_0000,
    ST_DIVE = 11'b001_0000_0000,
    ST_COPY = 11'b010_0000_0000,
    ST_OUT  = 11'b100_0000_0000
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumUnknowns - 1);
  localparam logic [jls_pkg::DivCntW-1:0] LastStep = jls_pkg::DivCntW'(jls_pkg::DivW - 1);

  state_e                      state_q, state_d;
  logic [IdxW-1:0]             i_q, i_d, j_q, j_d;
  logic [7:0]                  sweep_q, sweep_d;
  logic [7:0]                  iter_q;
  logic [jls_pkg::DivCntW-1:0] step_q, step_d;
  logic                        accept, in_range;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign in_range = (int'(row_i) < NumUnknowns) && (int'(col_i) < NumUnknowns);
  assign i_idx_o  = i_q;
  assign j_idx_o  = j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= jls_pkg::IterReset;
    end else if (cfg_we_i && cfg_idx_i == jls_pkg::CfgIterIdx) begin
      iter_q <= cfg_iter_i;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    sweep_d = sweep_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.ld_coef = accept && req_type_i == jls_pkg::REQ_COEF && in_range;
    cmd_o.ld_rhs  = accept && req_type_i == jls_pkg::REQ_RHS && (int'(row_i) < NumUnknowns);
    case (state_q)
      ST_IDLE: begin
        if (accept && req_type_i == jls_pkg::REQ_SOLVE) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        sweep_d    = '0;
        i_d        = '0;
        j_d        = '0;
        state_d    = (iter_q == 8'd0) ? ST_OUT : ST_ROW;
      end
      ST_ROW: begin
        cmd_o.load_b = 1'b1;
        j_d          = '0;
        state_d      = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc  = 1'b1;
        cmd_o.diag = (i_q == j_q);
        if (j_q == LastIdx) begin
          state_d = ST_DIVS;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_DIVS: begin
        cmd_o.div_start = 1'b1;
        step_d          = '0;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LastStep) state_d = ST_DIVE;
      end
      ST_DIVE: begin
        cmd_o.div_end = 1'b1;
        if (i_q == LastIdx) begin
          state_d = ST_COPY;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_ROW;
        end
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        sweep_d    = sweep_q + 8'd1;
        i_d        = '0;
        j_d        = '0;
        state_d    = (sweep_q + 8'd1 == iter_q) ? ST_OUT : ST_ROW;
      end
      ST_OUT: begin
        cmd_o.out      = 1'b1;
        cmd_o.out_last = (j_q == LastIdx);
        if (j_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      sweep_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      sweep_q <= sweep_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- hw/rtl/jls_dp.sv -----
// Datapath of the Jacobi solver: stores, multiply-accumulate, restoring divider, result beat.
// Depends on jls_pkg; commanded by jls_ctrl.
module jls_dp #(
  parameter int NumUnknowns = jls_pkg::DefNumUnknowns,
  parameter int IdxW        = $clog2(NumUnknowns)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  jls_pkg::jls_cmd_t            cmd_i,
  input  logic [IdxW-1:0]              i_idx_i,
  input  logic [IdxW-1:0]              j_idx_i,
  input  logic [2:0]                   row_i,
  input  logic [2:0]                   col_i,
  input  logic signed [31:0]           value_i,
  input  logic                         cfg_we_i,
  input  logic [jls_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic signed [31:0]           cfg_wdata_i,
  output logic                         valid_o,
  output logic [2:0]                   index_o,
  output logic signed [31:0]           solution_o,
  output logic                         fault_o,
  output logic                         last_o
);

  localparam int AccW = jls_pkg::AccW;
  localparam int DivW = jls_pkg::DivW;
  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  logic signed [31:0] coef_mem [NumUnknowns][NumUnknowns];
  logic signed [31:0] rhs_q    [NumUnknowns];
  logic signed [31:0] prev_q   [NumUnknowns];
  logic signed [31:0] next_q   [NumUnknowns];
  logic [NumUnknowns-1:0] flt_q;
  logic signed [31:0] guess_q;

  logic signed [31:0]   a_rd_q, x_rd_q, den_q;
  logic signed [63:0]   prod_q, prod_adj, term;
  logic signed [AccW-1:0] acc_q;
  logic [AccW-1:0]      un;
  logic [31:0]          ud_q, rem_q;
  logic [DivW-1:0]      dvd_q;
  logic [32:0]          quot_q, rem_s, limit;
  logic                 ovf_q, neg_q, ge;
  logic signed [31:0]   res;
  logic                 res_flt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guess_q <= jls_pkg::GuessReset;
    end else if (cfg_we_i && cfg_idx_i == jls_pkg::CfgGuessIdx) begin
      guess_q <= cfg_wdata_i;
    end
  end

  // Coefficient memory: one write port for loads, one registered read port for sweeps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_coef) coef_mem[IdxW'(row_i)][IdxW'(col_i)] <= value_i;
    if (cmd_i.rd) begin
      a_rd_q <= coef_mem[i_idx_i][j_idx_i];
      x_rd_q <= prev_q[j_idx_i];
    end
    if (cmd_i.ld_rhs) rhs_q[IdxW'(row_i)] <= value_i;
  end

  // Product truncated toward zero to Q16.16.
  assign prod_adj = prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0);
  assign term     = prod_adj >>> jls_pkg::FracBits;
  assign un       = acc_q[AccW-1] ? AccW'(-acc_q) : acc_q;

  assign rem_s = {rem_q, dvd_q[DivW-1]};
  assign ge    = rem_s >= {1'b0, ud_q};
  assign limit = neg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;

  always_comb begin
    res     = '0;
    res_flt = 1'b0;
    if (den_q == 32'sd0) begin
      res     = acc_q[AccW-1] ? SatMin : SatMax;
      res_flt = 1'b1;
    end else if (ovf_q || quot_q > limit) begin
      res     = neg_q ? SatMin : SatMax;
      res_flt = 1'b1;
    end else if (neg_q) begin
      res = 32'(33'd0 - quot_q);
    end else begin
      res = quot_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= a_rd_q * x_rd_q;
    if (cmd_i.load_b) acc_q <= AccW'(rhs_q[i_idx_i]);
    if (cmd_i.acc) begin
      if (cmd_i.diag) den_q <= a_rd_q;
      else            acc_q <= acc_q - AccW'(term);
    end
    if (cmd_i.div_start) begin
      neg_q  <= acc_q[AccW-1] != den_q[31];
      ud_q   <= den_q[31] ? 32'(-den_q) : den_q;
      dvd_q  <= {un, {jls_pkg::FracBits{1'b0}}};
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? 32'(rem_s - {1'b0, ud_q}) : rem_s[31:0];
      dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      quot_q <= {quot_q[31:0], ge};
      ovf_q  <= ovf_q | quot_q[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumUnknowns; k++) begin
        prev_q[k] <= '0;
        next_q[k] <= '0;
      end
      flt_q <= '0;
    end else begin
      if (cmd_i.init) begin
        for (int k = 0; k < NumUnknowns; k++) begin
          prev_q[k] <= guess_q;
          next_q[k] <= guess_q;
        end
        flt_q <= '0;
      end
      if (cmd_i.div_end) begin
        next_q[i_idx_i] <= res;
        if (res_flt) flt_q[i_idx_i] <= 1'b1;
      end
      if (cmd_i.copy) begin
        for (int k = 0; k < NumUnknowns; k++) prev_q[k] <= next_q[k];
      end
    end
  end

  // The last flag is only high together with the beat that it marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
    end else begin
      valid_o <= cmd_i.out;
      last_o  <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      index_o    <= 3'(j_idx_i);
      solution_o <= prev_q[j_idx_i];
      fault_o    <= flt_q[j_idx_i];
    end
  end

endmodule

// ----- hw/rtl/jacobi_linear_solver.sv -----
// Jacobi linear solver, Q16.16 fixed point.
// Top level: joins the jls_ctrl sequencer and the jls_dp datapath; depends on jls_pkg.
//
// Usage: an item is taken when start_i is high and busy_o is low. req_type_i selects a
// coefficient load (row_i, col_i, value_i), a right-hand-side load (row_i, value_i) or a
// solve. Loads leave busy_o low, so loads can stream one per cycle while no solve runs.
// A solve raises busy_o and runs iteration_count sweeps. Each unknown of a sweep takes
// a right-hand-side load, then a registered coefficient read, multiply and accumulate per
// column, then the divider setup, DivW = 72 restoring steps and the write-back; each sweep
// ends with a copy step. The N result beats then follow on consecutive cycles, marked by
// valid_o, with last_o on the final one; busy_o falls as the final beat is shown.
// The receiver cannot stall: each beat is shown for one cycle.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes iteration_count
// (index 0) or initial_guess (index 1); other indexes are ignored.
// Reset sets iteration_count to 10 and initial_guess to 1.0 and leaves the block idle.
// Coefficient and right-hand-side stores hold no reset value until written.
module jacobi_linear_solver #(
  parameter int NUM_UNKNOWNS = jls_pkg::DefNumUnknowns
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   req_type_i,
  input  logic [2:0]                   row_i,
  input  logic [2:0]                   col_i,
  input  logic signed [31:0]           value_i,
  input  logic                         cfg_we_i,
  input  logic [jls_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  output logic                         valid_o,
  output logic [2:0]                   index_o,
  output logic signed [31:0]           solution_o,
  output logic                         fault_o,
  output logic                         last_o
);

  localparam int IdxW = $clog2(NUM_UNKNOWNS);

  jls_pkg::jls_cmd_t cmd;
  logic [IdxW-1:0]   i_idx, j_idx;

  jls_ctrl #(
    .NumUnknowns(NUM_UNKNOWNS),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_iter_i (cfg_wdata_i[7:0]),
    .busy_o     (busy_o),
    .cmd_o      (cmd),
    .i_idx_o    (i_idx),
    .j_idx_o    (j_idx)
  );

  jls_dp #(
    .NumUnknowns(NUM_UNKNOWNS),
    .IdxW       (IdxW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .i_idx_i     (i_idx),
    .j_idx_i     (j_idx),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (valid_o),
    .index_o     (index_o),
    .solution_o  (solution_o),
    .fault_o     (fault_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  // The final beat of a solve always carries a valid strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni) last_o |-> valid_o)
    else $error("last_o without valid_o");
  // Beats before the last one appear while the solve is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (valid_o && !last_o) |-> busy_o)
    else $error("result beat while idle");
  // A solve's result burst starts at unknown zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(valid_o) |-> index_o == 3'd0)
    else $error("result burst does not start at index zero");
  // Results follow back to back in index order until the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (valid_o && index_o == 3'($past(index_o) + 3'd1)))
    else $error("result burst broken or out of order");
`endif

endmodule
